[hw/rtl/pair_mass_reconstruction_core_defines.svh]
// ---------------------------------------------------------------------------
// Pair mass reconstruction defines
// Assertion macros used by the checker file of the block.
// ---------------------------------------------------------------------------
`ifndef PAIR_MASS_RECONSTRUCTION_CORE_DEFINES_SVH
`define PAIR_MASS_RECONSTRUCTION_CORE_DEFINES_SVH

// Antecedent in this cycle, consequent in the next one.
`define PMR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pmr check failed");

// Antecedent and consequent in the same cycle.
`define PMR_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pmr check failed");

`endif

[hw/rtl/pmr_pkg.sv]
// ---------------------------------------------------------------------------
// Pair mass reconstruction package
// Shared widths, codes, controller states and command types.
// ---------------------------------------------------------------------------
package pmr_pkg;

   localparam int DEF_MAX_VECTORS = 5;
   localparam int COMP_W          = 24;
   localparam int SUM_W           = 25;
   localparam int PICK_W          = 4;
   localparam int OPND_W          = 26;
   localparam int SQ_W            = 51;
   localparam int ACC_W           = 53;
   localparam int RAD_W           = 50;
   localparam int ROOT_W          = 25;
   localparam int REM_W           = 27;
   localparam int MASS_W          = 26;
   localparam int DIST_W          = 27;
   localparam int PT_W            = 50;
   localparam int STEP_W          = 5;
   localparam int ROOT_STEPS      = 25;
   localparam int MASS_SQ_STEPS   = 4;
   localparam int PT_SQ_STEPS     = 2;
   localparam logic [COMP_W-1:0] TARGET_RESET = 24'd80400;

   typedef struct packed {
      logic signed [COMP_W-1:0] x;
      logic signed [COMP_W-1:0] y;
      logic signed [COMP_W-1:0] z;
      logic [COMP_W-1:0]        e;
   } vec_type;

   typedef enum logic {
      CSR_TARGET_MASS = 1'b0,
      CSR_SELECT_MODE = 1'b1
   } csr_idx_type;

   typedef enum logic {
      MODE_MASS = 1'b0,
      MODE_PT   = 1'b1
   } mode_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MS_RD, ST_MS_SUM, ST_MS_SQ, ST_ROOT_INIT, ST_ROOT, ST_MS_CMP,
      ST_PT_RD, ST_PT_SUM, ST_PT_SQ, ST_PT_UPD, ST_EM_RD, ST_EM_SUM, ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      SQ_E, SQ_X, SQ_Y, SQ_Z
   } sq_sel_type;

   typedef enum logic [1:0] {
      ACC_NONE, ACC_LOAD, ACC_ADD, ACC_SUB
   } acc_op_type;

   typedef struct packed {
      logic              wr_en;
      logic              rd_pick;
      logic [PICK_W-1:0] idx_a;
      logic [PICK_W-1:0] idx_b;
      logic              sum_en;
      logic              sq_en;
      sq_sel_type        sq_sel;
      acc_op_type        acc_op;
      logic              root_init;
      logic              root_step;
      logic              mass_cmp;
      logic              pt_upd;
      logic              clear_best;
      logic              out_load;
      logic              out_flag;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
   } sts_type;

endpackage

[hw/rtl/pmr_ctrl.sv]
// ---------------------------------------------------------------------------
// Pair mass reconstruction controller
// Load counting, pair and vector sequencing, result handshake.
// ---------------------------------------------------------------------------
module pmr_ctrl import pmr_pkg::*; #(
   parameter int MAX_VECTORS = DEF_MAX_VECTORS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  logic    req_last_vector,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam int CNTW = $clog2(MAX_VECTORS + 1);

   state_type         state_ff, state_in;
   logic [CNTW-1:0]   count_ff, count_in;
   logic              ovf_ff, ovf_in;
   logic [CNTW-1:0]   ia_ff, ia_in;
   logic [CNTW-1:0]   ib_ff, ib_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              flag_ff, flag_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [CNTW-1:0] n_now;
   logic            ovf_now;
   logic [CNTW:0]   ia_next, ia_skip, ib_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         ia_ff        <= '0;
         ib_ff        <= '0;
         step_ff      <= '0;
         flag_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         ia_ff        <= ia_in;
         ib_ff        <= ib_in;
         step_ff      <= step_in;
         flag_ff      <= flag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign req_ready = (state_ff == ST_IDLE);
   assign ia_next   = {1'b0, ia_ff} + (CNTW+1)'(1);
   assign ia_skip   = {1'b0, ia_ff} + (CNTW+1)'(2);
   assign ib_next   = {1'b0, ib_ff} + (CNTW+1)'(1);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      ia_in        = ia_ff;
      ib_in        = ib_ff;
      step_in      = step_ff;
      flag_in      = flag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.sq_sel   = SQ_E;
      cmd.acc_op   = ACC_NONE;
      cmd.idx_a    = PICK_W'(ia_ff);
      cmd.idx_b    = PICK_W'(ib_ff);
      n_now        = count_ff;
      ovf_now      = ovf_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.idx_a = PICK_W'(count_ff);
               if (count_ff < CNTW'(MAX_VECTORS)) begin
                  cmd.wr_en = 1'b1;
                  n_now     = count_ff + CNTW'(1);
               end else begin
                  ovf_now   = 1'b1;
               end
               count_in = n_now;
               ovf_in   = ovf_now;
               if (req_last_vector) begin
                  // Close the set: start from zero picks.
                  cmd.clear_best = 1'b1;
                  flag_in        = ovf_now;
                  ia_in          = '0;
                  ib_in          = CNTW'(1);
                  step_in        = '0;
                  if (ovf_now || n_now < CNTW'(2)) begin
                     state_in = ST_EM_RD;
                  end else if (sts.mode == MODE_MASS) begin
                     state_in = ST_MS_RD;
                  end else begin
                     state_in = ST_PT_RD;
                  end
               end
            end
         end
         ST_MS_RD:  state_in = ST_MS_SUM;
         ST_MS_SUM: begin
            cmd.sum_en = 1'b1;
            step_in    = '0;
            state_in   = ST_MS_SQ;
         end
         ST_MS_SQ: begin
            cmd.sq_en  = (step_ff < STEP_W'(MASS_SQ_STEPS));
            cmd.sq_sel = sq_sel_type'(step_ff[1:0]);
            if (step_ff == '0) begin
               cmd.acc_op = ACC_NONE;
            end else if (step_ff == STEP_W'(1)) begin
               cmd.acc_op = ACC_LOAD;
            end else begin
               cmd.acc_op = ACC_SUB;
            end
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(MASS_SQ_STEPS)) begin
               state_in = ST_ROOT_INIT;
            end
         end
         ST_ROOT_INIT: begin
            cmd.root_init = 1'b1;
            step_in       = '0;
            state_in      = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            step_in       = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(ROOT_STEPS - 1)) begin
               state_in = ST_MS_CMP;
            end
         end
         ST_MS_CMP: begin
            cmd.mass_cmp = 1'b1;
            // Advance in order (0,1),(0,2),...,(n-2,n-1).
            if (ib_next < {1'b0, count_ff}) begin
               ib_in    = ib_next[CNTW-1:0];
               state_in = ST_MS_RD;
            end else if (ia_skip < {1'b0, count_ff}) begin
               ia_in    = ia_next[CNTW-1:0];
               ib_in    = ia_skip[CNTW-1:0];
               state_in = ST_MS_RD;
            end else begin
               state_in = ST_EM_RD;
            end
         end
         ST_PT_RD: begin
            cmd.idx_b = PICK_W'(ia_ff);
            state_in  = ST_PT_SUM;
         end
         ST_PT_SUM: begin
            cmd.sum_en = 1'b1;
            step_in    = '0;
            state_in   = ST_PT_SQ;
         end
         ST_PT_SQ: begin
            cmd.sq_en  = (step_ff < STEP_W'(PT_SQ_STEPS));
            cmd.sq_sel = (step_ff == '0) ? SQ_X : SQ_Y;
            if (step_ff == '0) begin
               cmd.acc_op = ACC_NONE;
            end else if (step_ff == STEP_W'(1)) begin
               cmd.acc_op = ACC_LOAD;
            end else begin
               cmd.acc_op = ACC_ADD;
            end
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(PT_SQ_STEPS)) begin
               state_in = ST_PT_UPD;
            end
         end
         ST_PT_UPD: begin
            cmd.pt_upd = 1'b1;
            if (ia_next < {1'b0, count_ff}) begin
               ia_in    = ia_next[CNTW-1:0];
               state_in = ST_PT_RD;
            end else begin
               state_in = ST_EM_RD;
            end
         end
         ST_EM_RD: begin
            cmd.rd_pick = 1'b1;
            state_in    = ST_EM_SUM;
         end
         ST_EM_SUM: begin
            cmd.sum_en = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            // Hold until the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               cmd.out_flag = flag_ff;
               rsp_valid_in = 1'b1;
               count_in     = '0;
               ovf_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

[hw/rtl/pmr_datapath.sv]
// ---------------------------------------------------------------------------
// Pair mass reconstruction datapath
// Vector store, pair sums, square-accumulate, bit-serial root, selection.
// ---------------------------------------------------------------------------
module pmr_datapath import pmr_pkg::*; #(
   parameter int MAX_VECTORS = DEF_MAX_VECTORS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output sts_type                  sts,
   input  logic                     csr_we,
   input  logic                     csr_index,
   input  logic [COMP_W-1:0]        csr_wdata,
   input  logic signed [COMP_W-1:0] req_mom_x,
   input  logic signed [COMP_W-1:0] req_mom_y,
   input  logic signed [COMP_W-1:0] req_mom_z,
   input  logic [COMP_W-1:0]        req_energy,
   output logic signed [SUM_W-1:0]  rsp_sum_x,
   output logic signed [SUM_W-1:0]  rsp_sum_y,
   output logic signed [SUM_W-1:0]  rsp_sum_z,
   output logic [SUM_W-1:0]         rsp_sum_energy,
   output logic [PICK_W-1:0]        rsp_first_pick,
   output logic [PICK_W-1:0]        rsp_second_pick,
   output logic                     rsp_too_many
);

   localparam int IDXW = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;

   vec_type mem [MAX_VECTORS];

   logic [COMP_W-1:0] target_ff;
   mode_type          mode_ff;

   logic [IDXW-1:0] addr_a, addr_b;
   vec_type         rd_a_ff, rd_b_ff;
   logic            same_ff;

   logic signed [SUM_W-1:0] sx_ff, sy_ff, sz_ff;
   logic [SUM_W-1:0]        se_ff;

   logic signed [OPND_W-1:0]   opnd;
   logic signed [2*OPND_W-1:0] sq_full;
   logic [SQ_W-1:0]            prod_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   logic signed [ACC_W-1:0]    acc_neg;

   logic              neg_ff;
   logic [RAD_W-1:0]  rad_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [REM_W+1:0]  rem_try, rem_sub;

   logic signed [MASS_W-1:0] mass;
   logic signed [DIST_W-1:0] diff;
   logic [DIST_W-1:0]        mass_dist;
   logic [DIST_W-1:0]        best_ff;
   logic                     best_vld_ff;

   logic [IDXW-1:0] pick_a_ff, pick_b_ff;
   logic [PT_W-1:0] pt0_ff, pt1_ff;
   logic [IDXW-1:0] r0_sw, r1_sw;
   logic [PT_W-1:0] p0_sw, p1_sw;
   logic [PT_W-1:0] pt_cur;
   logic [IDXW-1:0] cur_idx;

   logic signed [SUM_W-1:0] out_x_ff, out_y_ff, out_z_ff;
   logic [SUM_W-1:0]        out_e_ff;
   logic [PICK_W-1:0]       out_lo_ff, out_hi_ff;
   logic                    out_flag_ff;

   assign sts.mode = mode_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= TARGET_RESET;
         mode_ff   <= MODE_MASS;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_TARGET_MASS: target_ff <= csr_wdata;
            CSR_SELECT_MODE: mode_ff   <= mode_type'(csr_wdata[0]);
            default:         target_ff <= target_ff;
         endcase
      end
   end

   // Vector store: one write port, two registered read ports.
   assign addr_a  = cmd.rd_pick ? pick_a_ff : cmd.idx_a[IDXW-1:0];
   assign addr_b  = cmd.rd_pick ? pick_b_ff : cmd.idx_b[IDXW-1:0];
   assign cur_idx = cmd.idx_a[IDXW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cur_idx] <= '{x: req_mom_x, y: req_mom_y, z: req_mom_z, e: req_energy};
      end
      rd_a_ff <= mem[addr_a];
      rd_b_ff <= mem[addr_b];
      same_ff <= (addr_a == addr_b);
   end

   // Pair sum, or a single vector when both reads hit one entry.
   always_ff @(posedge clock) begin
      if (cmd.sum_en) begin
         if (same_ff) begin
            sx_ff <= SUM_W'(rd_a_ff.x);
            sy_ff <= SUM_W'(rd_a_ff.y);
            sz_ff <= SUM_W'(rd_a_ff.z);
            se_ff <= SUM_W'(rd_a_ff.e);
         end else begin
            sx_ff <= SUM_W'(rd_a_ff.x) + SUM_W'(rd_b_ff.x);
            sy_ff <= SUM_W'(rd_a_ff.y) + SUM_W'(rd_b_ff.y);
            sz_ff <= SUM_W'(rd_a_ff.z) + SUM_W'(rd_b_ff.z);
            se_ff <= {1'b0, rd_a_ff.e} + {1'b0, rd_b_ff.e};
         end
      end
   end

   // Shared squarer, one operand a cycle; the registered product is accumulated in the cycle after.
   always_comb begin
      unique case (cmd.sq_sel)
         SQ_E:    opnd = $signed({1'b0, se_ff});
         SQ_X:    opnd = OPND_W'(sx_ff);
         SQ_Y:    opnd = OPND_W'(sy_ff);
         SQ_Z:    opnd = OPND_W'(sz_ff);
         default: opnd = '0;
      endcase
   end

   assign sq_full = opnd * opnd;

   always_ff @(posedge clock) begin
      if (cmd.sq_en) begin
         prod_ff <= sq_full[SQ_W-1:0];
      end
      unique case (cmd.acc_op)
         ACC_LOAD: acc_ff <= $signed({{(ACC_W-SQ_W){1'b0}}, prod_ff});
         ACC_ADD:  acc_ff <= acc_ff + $signed({{(ACC_W-SQ_W){1'b0}}, prod_ff});
         ACC_SUB:  acc_ff <= acc_ff - $signed({{(ACC_W-SQ_W){1'b0}}, prod_ff});
         default:  acc_ff <= acc_ff;
      endcase
   end

   // Restoring square root, one result bit a cycle.
   assign acc_neg = -acc_ff;
   assign rem_try = {rem_ff, rad_ff[RAD_W-1 -: 2]};
   assign rem_sub = rem_try - {2'b00, root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (cmd.root_init) begin
         neg_ff  <= acc_ff[ACC_W-1];
         rad_ff  <= acc_ff[ACC_W-1] ? acc_neg[RAD_W-1:0] : acc_ff[RAD_W-1:0];
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (cmd.root_step) begin
         rad_ff <= {rad_ff[RAD_W-3:0], 2'b00};
         if (rem_try >= {2'b00, root_ff, 2'b01}) begin
            rem_ff  <= rem_sub[REM_W-1:0];
            root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_try[REM_W-1:0];
            root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
   end

   // Distance of the signed mass from the target.
   assign mass      = neg_ff ? -$signed({1'b0, root_ff}) : $signed({1'b0, root_ff});
   assign diff      = DIST_W'(mass) - $signed({{(DIST_W-COMP_W){1'b0}}, target_ff});
   assign mass_dist = diff[DIST_W-1] ? DIST_W'(-diff) : DIST_W'(diff);

   // Two highest pT: swap the leaders, then test the new vector.
   assign pt_cur = acc_ff[PT_W-1:0];
   always_comb begin
      if (pt0_ff < pt1_ff) begin
         r0_sw = pick_b_ff;
         r1_sw = pick_a_ff;
         p0_sw = pt1_ff;
         p1_sw = pt0_ff;
      end else begin
         r0_sw = pick_a_ff;
         r1_sw = pick_b_ff;
         p0_sw = pt0_ff;
         p1_sw = pt1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_vld_ff <= 1'b0;
         pick_a_ff   <= '0;
         pick_b_ff   <= '0;
      end else if (cmd.clear_best) begin
         best_vld_ff <= 1'b0;
         pick_a_ff   <= '0;
         pick_b_ff   <= '0;
      end else if (cmd.mass_cmp) begin
         if (!best_vld_ff || mass_dist < best_ff) begin
            best_vld_ff <= 1'b1;
            best_ff     <= mass_dist;
            pick_a_ff   <= cur_idx;
            pick_b_ff   <= cmd.idx_b[IDXW-1:0];
         end
      end else if (cmd.pt_upd) begin
         if (cur_idx == IDXW'(0)) begin
            pick_a_ff <= cur_idx;
            pt0_ff    <= pt_cur;
         end else if (cur_idx == IDXW'(1)) begin
            pick_b_ff <= cur_idx;
            pt1_ff    <= pt_cur;
         end else begin
            pick_a_ff <= r0_sw;
            pt0_ff    <= p0_sw;
            if (pt_cur > p1_sw) begin
               pick_b_ff <= cur_idx;
               pt1_ff    <= pt_cur;
            end else begin
               pick_b_ff <= r1_sw;
               pt1_ff    <= p1_sw;
            end
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_x_ff    <= sx_ff;
         out_y_ff    <= sy_ff;
         out_z_ff    <= sz_ff;
         out_e_ff    <= se_ff;
         out_lo_ff   <= PICK_W'((pick_a_ff < pick_b_ff) ? pick_a_ff : pick_b_ff);
         out_hi_ff   <= PICK_W'((pick_a_ff < pick_b_ff) ? pick_b_ff : pick_a_ff);
         out_flag_ff <= cmd.out_flag;
      end
   end

   assign rsp_sum_x       = out_x_ff;
   assign rsp_sum_y       = out_y_ff;
   assign rsp_sum_z       = out_z_ff;
   assign rsp_sum_energy  = out_e_ff;
   assign rsp_first_pick  = out_lo_ff;
   assign rsp_second_pick = out_hi_ff;
   assign rsp_too_many    = out_flag_ff;

endmodule

[hw/rtl/pair_mass_reconstruction_core.sv]
// ---------------------------------------------------------------------------
// Pair mass reconstruction core
// Loads a set of four-momenta and returns the pair closest to a target mass
// or the two highest-pT vectors.
// ---------------------------------------------------------------------------
// A set is loaded one vector per request transaction; the transaction with
// last_vector closes it and yields one response transaction. In mass mode
// every unordered pair is read and summed, squared and accumulated on the
// shared squarer, set up for and passed through the bit-serial square root,
// and compared with the best so far. In pT mode each vector is read, squared
// on the same squarer and tested against the two leaders. An overflowed set
// or a set of one goes straight to the final read-out. Requests are refused
// while a set is being evaluated; loading of the next set may proceed while
// the response still waits in the output register. The store has MAX_VECTORS
// entries; further vectors are dropped and too_many is raised.
// ---------------------------------------------------------------------------
module pair_mass_reconstruction_core import pmr_pkg::*; #(
   parameter int MAX_VECTORS = DEF_MAX_VECTORS
) (
   input  logic                     clock,
   input  logic                     reset,
   // Configuration writes
   input  logic                     csr_we,
   input  logic                     csr_index,
   input  logic [COMP_W-1:0]        csr_wdata,
   // Request channel: one four-vector per transaction
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [COMP_W-1:0] req_mom_x,
   input  logic signed [COMP_W-1:0] req_mom_y,
   input  logic signed [COMP_W-1:0] req_mom_z,
   input  logic [COMP_W-1:0]        req_energy,
   input  logic                     req_last_vector,
   // Response channel: chosen combination
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [SUM_W-1:0]  rsp_sum_x,
   output logic signed [SUM_W-1:0]  rsp_sum_y,
   output logic signed [SUM_W-1:0]  rsp_sum_z,
   output logic [SUM_W-1:0]         rsp_sum_energy,
   output logic [PICK_W-1:0]        rsp_first_pick,
   output logic [PICK_W-1:0]        rsp_second_pick,
   output logic                     rsp_too_many
);

   cmd_type cmd;
   sts_type sts;

   // Sequencer: counts the set, walks pairs or vectors, owns rsp_valid.
   pmr_ctrl #(
      .MAX_VECTORS (MAX_VECTORS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_last_vector (req_last_vector),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .sts             (sts),
      .cmd             (cmd)
   );

   // Store, arithmetic and the output register.
   pmr_datapath #(
      .MAX_VECTORS (MAX_VECTORS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_mom_x       (req_mom_x),
      .req_mom_y       (req_mom_y),
      .req_mom_z       (req_mom_z),
      .req_energy      (req_energy),
      .rsp_sum_x       (rsp_sum_x),
      .rsp_sum_y       (rsp_sum_y),
      .rsp_sum_z       (rsp_sum_z),
      .rsp_sum_energy  (rsp_sum_energy),
      .rsp_first_pick  (rsp_first_pick),
      .rsp_second_pick (rsp_second_pick),
      .rsp_too_many    (rsp_too_many)
   );

endmodule

[hw/rtl/pmr_checker.sv]
// ---------------------------------------------------------------------------
// Pair mass reconstruction checker
// Port-level checks on the core, attached by bind.
// ---------------------------------------------------------------------------
`include "pair_mass_reconstruction_core_defines.svh"

module pmr_checker import pmr_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     req_last_vector,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [SUM_W-1:0]  rsp_sum_x,
   input logic [PICK_W-1:0]        rsp_first_pick,
   input logic [PICK_W-1:0]        rsp_second_pick,
   input logic                     rsp_too_many
);

   `PMR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_sum_x))

   `PMR_ASSERT_SAME(a_pick_order, clock, reset, rsp_valid, rsp_first_pick <= rsp_second_pick)

   `PMR_ASSERT_SAME(a_ovf_picks, clock, reset, rsp_valid && rsp_too_many, rsp_first_pick == '0 && rsp_second_pick == '0)

   `PMR_ASSERT_NEXT(a_busy_after_last, clock, reset, req_valid && req_ready && req_last_vector, !req_ready)

endmodule

bind pair_mass_reconstruction_core pmr_checker u_pmr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_last_vector (req_last_vector),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_sum_x       (rsp_sum_x),
   .rsp_first_pick  (rsp_first_pick),
   .rsp_second_pick (rsp_second_pick),
   .rsp_too_many    (rsp_too_many)
);

[verif/tb_pair_mass_reconstruction_core.sv]
// ---------------------------------------------------------------------------
// Pair mass reconstruction core testbench
// Loads sets of four-vectors through the request channel, predicts the chosen
// combination of each set, and checks every response field by field under
// several target masses and both selection modes, with random idling.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_pair_mass_reconstruction_core;
   import pmr_pkg::*;

   localparam int NVEC        = DEF_MAX_VECTORS;
   localparam int IDLE_LIMIT  = 5000;
   localparam int DRAIN_WAIT  = 400;
   localparam int HOLD_CYCLES = 700;

   typedef struct {
      logic signed [SUM_W-1:0] x;
      logic signed [SUM_W-1:0] y;
      logic signed [SUM_W-1:0] z;
      logic [SUM_W-1:0]        e;
      logic [PICK_W-1:0]       lo;
      logic [PICK_W-1:0]       hi;
      logic                    flag;
   } pick_result;

   // Predicts the pick of each set and holds the expected responses.
   class pair_scoreboard;
      vec_type           held[NVEC];
      int                count;
      bit                overflow;
      logic [COMP_W-1:0] target;
      mode_type          mode;
      pick_result        pending[$];
      int                errors;

      function new();
         count    = 0;
         overflow = 0;
         target   = TARGET_RESET;
         mode     = MODE_MASS;
         errors   = 0;
      endfunction

      function void write_reg(csr_idx_type idx, logic [COMP_W-1:0] d);
         if (idx == CSR_TARGET_MASS) target = d;
         else mode = mode_type'(d[0]);
      endfunction

      function longint unsigned isqrt(longint unsigned v);
         longint unsigned res;
         longint unsigned probe;
         res   = 0;
         probe = 64'd1 << 62;
         while (probe > v) probe >>= 2;
         while (probe != 0) begin
            if (v >= res + probe) begin
               v   = v - (res + probe);
               res = (res >> 1) + probe;
            end else begin
               res >>= 1;
            end
            probe >>= 2;
         end
         return res;
      endfunction

      function longint pair_mass(int a, int b);
         longint x, y, z, e, m2;
         x  = longint'(held[a].x) + longint'(held[b].x);
         y  = longint'(held[a].y) + longint'(held[b].y);
         z  = longint'(held[a].z) + longint'(held[b].z);
         e  = longint'(held[a].e) + longint'(held[b].e);
         m2 = e * e - x * x - y * y - z * z;
         if (m2 < 0) return -longint'(isqrt(longint'(-m2)));
         return longint'(isqrt(m2));
      endfunction

      function longint pt2(int a);
         return longint'(held[a].x) * longint'(held[a].x) +
                longint'(held[a].y) * longint'(held[a].y);
      endfunction

      function pick_result combine(int a, int b, bit flag);
         pick_result r;
         longint x, y, z, e;
         x = held[a].x; y = held[a].y; z = held[a].z; e = longint'(held[a].e);
         if (a != b) begin
            x += held[b].x; y += held[b].y; z += held[b].z; e += longint'(held[b].e);
         end
         r.x    = x[SUM_W-1:0];
         r.y    = y[SUM_W-1:0];
         r.z    = z[SUM_W-1:0];
         r.e    = e[SUM_W-1:0];
         r.lo   = PICK_W'((a < b) ? a : b);
         r.hi   = PICK_W'((a < b) ? b : a);
         r.flag = flag;
         return r;
      endfunction

      function void note_vector(vec_type v, bit last);
         longint best, d;
         int     ba, bb, r0, r1, t;
         if (count < NVEC) begin
            held[count] = v;
            count++;
         end else begin
            overflow = 1;
         end
         if (!last) return;
         if (overflow) begin
            pending.push_back(combine(0, 0, 1));
         end else if (count < 2) begin
            pending.push_back(combine(0, 0, 0));
         end else if (mode == MODE_MASS) begin
            best = -1; ba = 0; bb = 1;
            for (int a = 0; a + 1 < count; a++)
               for (int b = a + 1; b < count; b++) begin
                  d = pair_mass(a, b) - longint'(target);
                  if (d < 0) d = -d;
                  // strict compare: the first pair keeps a tie
                  if (best < 0 || d < best) begin
                     best = d; ba = a; bb = b;
                  end
               end
            pending.push_back(combine(ba, bb, 0));
         end else begin
            r0 = 0; r1 = 1;
            for (int i = 2; i < count; i++) begin
               if (pt2(r0) < pt2(r1)) begin
                  t = r0; r0 = r1; r1 = t;
               end
               if (pt2(i) > pt2(r1)) r1 = i;
            end
            pending.push_back(combine(r0, r1, 0));
         end
         count    = 0;
         overflow = 0;
      endfunction

      function void compare(string name, longint expv, longint actv);
         if (expv != actv) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, expv, actv);
         end
      endfunction

      function void check_result(pick_result act);
         pick_result ex;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected response, expected none actual x=%0d", $time, act.x);
            return;
         end
         ex = pending.pop_front();
         compare("sum_x", ex.x, act.x);
         compare("sum_y", ex.y, act.y);
         compare("sum_z", ex.z, act.z);
         compare("sum_energy", ex.e, act.e);
         compare("first_pick", ex.lo, act.lo);
         compare("second_pick", ex.hi, act.hi);
         compare("too_many", ex.flag, act.flag);
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     csr_we;
   logic                     csr_index;
   logic [COMP_W-1:0]        csr_wdata;
   logic                     req_valid;
   logic                     req_ready;
   logic signed [COMP_W-1:0] req_mom_x;
   logic signed [COMP_W-1:0] req_mom_y;
   logic signed [COMP_W-1:0] req_mom_z;
   logic [COMP_W-1:0]        req_energy;
   logic                     req_last_vector;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic signed [SUM_W-1:0]  rsp_sum_x;
   logic signed [SUM_W-1:0]  rsp_sum_y;
   logic signed [SUM_W-1:0]  rsp_sum_z;
   logic [SUM_W-1:0]         rsp_sum_energy;
   logic [PICK_W-1:0]        rsp_first_pick;
   logic [PICK_W-1:0]        rsp_second_pick;
   logic                     rsp_too_many;

   pair_scoreboard sb;
   bit             hold_request;
   int             idle_cycles;

   pair_mass_reconstruction_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mom_x       (req_mom_x),
      .req_mom_y       (req_mom_y),
      .req_mom_z       (req_mom_z),
      .req_energy      (req_energy),
      .req_last_vector (req_last_vector),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_sum_x       (rsp_sum_x),
      .rsp_sum_y       (rsp_sum_y),
      .rsp_sum_z       (rsp_sum_z),
      .rsp_sum_energy  (rsp_sum_energy),
      .rsp_first_pick  (rsp_first_pick),
      .rsp_second_pick (rsp_second_pick),
      .rsp_too_many    (rsp_too_many)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Check every response transaction against the oldest prediction.
   always @(posedge clock) begin
      pick_result act;
      if (!reset && rsp_valid && rsp_ready) begin
         act.x    = rsp_sum_x;
         act.y    = rsp_sum_y;
         act.z    = rsp_sum_z;
         act.e    = rsp_sum_energy;
         act.lo   = rsp_first_pick;
         act.hi   = rsp_second_pick;
         act.flag = rsp_too_many;
         sb.check_result(act);
      end
   end

   // Watchdog: count cycles in which no transaction moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // Receiver: random stall before each response, plus one long hold-off
   // when the stimulus asks for it so the block backs up into its input.
   initial begin
      int gap;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         gap = $urandom_range(0, 16);
         if (hold_request) begin
            hold_request = 0;
            gap = HOLD_CYCLES;
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   task automatic send_vec(logic signed [COMP_W-1:0] x, logic signed [COMP_W-1:0] y,
                           logic signed [COMP_W-1:0] z, logic [COMP_W-1:0] e, bit last);
      int      gap;
      vec_type v;
      gap = $urandom_range(0, 16);
      // leave a stretch without gaps now and then
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_mom_x       <= x;
      req_mom_y       <= y;
      req_mom_z       <= z;
      req_energy      <= e;
      req_last_vector <= last;
      do @(posedge clock); while (!(req_valid && req_ready));
      v.x = x; v.y = y; v.z = z; v.e = e;
      sb.note_vector(v, last);
   endtask

   // Random vector: mostly physical values near the W/Z scale, some raw bits.
   task automatic send_random(bit last);
      logic signed [COMP_W-1:0] x, y, z;
      logic [COMP_W-1:0]        e;
      if ($urandom_range(0, 3) == 0) begin
         x = COMP_W'($urandom);
         y = COMP_W'($urandom);
         z = COMP_W'($urandom);
         e = COMP_W'($urandom);
      end else begin
         x = COMP_W'($signed($urandom_range(0, 120000)) - 60000);
         y = COMP_W'($signed($urandom_range(0, 120000)) - 60000);
         z = COMP_W'($signed($urandom_range(0, 120000)) - 60000);
         if ($urandom_range(0, 4) == 0)
            e = COMP_W'($urandom_range(0, 40000));
         else
            e = COMP_W'((x < 0 ? -x : x) + (y < 0 ? -y : y) + (z < 0 ? -z : z)
                        + $urandom_range(0, 60000));
      end
      send_vec(x, y, z, e, last);
   endtask

   task automatic run_random(int items);
      int sent, n;
      sent = 0;
      while (sent < items) begin
         case ($urandom_range(0, 9))
            0: n = 1;
            1: n = $urandom_range(NVEC + 1, NVEC + 3);
            default: n = $urandom_range(2, NVEC);
         endcase
         for (int i = 0; i < n; i++) send_random(i == n - 1);
         sent += n;
      end
   endtask

   // Drain all responses and let the block settle before a register write.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // Hold the write enable; the caller drops it after the last write.
   task automatic write_csr(csr_idx_type idx, logic [COMP_W-1:0] d);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
      sb.write_reg(idx, d);
   endtask

   task automatic set_config(logic [COMP_W-1:0] tgt, mode_type m);
      wait_idle();
      write_csr(CSR_TARGET_MASS, tgt);
      write_csr(CSR_SELECT_MODE, COMP_W'(m));
      csr_we <= 1'b0;
   endtask

   initial begin
      sb              = new();
      hold_request    = 0;
      idle_cycles     = 0;
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = CSR_TARGET_MASS;
      csr_wdata       = '0;
      req_valid       = 1'b0;
      req_mom_x       = '0;
      req_mom_y       = '0;
      req_mom_z       = '0;
      req_energy      = '0;
      req_last_vector = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed sets under reset configuration.
      // single vector with extreme fields
      send_vec(-24'sd8388608, 24'sd8388607, 24'sd0, 24'hFFFFFF, 1);
      // extremes on both ends; the momenta of the pair almost cancel
      send_vec(24'sd8388607, 24'sd8388607, 24'sd8388607, 24'hFFFFFF, 0);
      send_vec(-24'sd8388608, -24'sd8388608, -24'sd8388608, 24'h000000, 1);
      // identical vectors: first pair wins the tie
      for (int i = 0; i < 3; i++) send_vec(24'sd1000, -24'sd2000, 24'sd3000, 24'd45000, i == 2);
      // overflowing set returns the first vector flagged
      for (int i = 0; i < NVEC + 2; i++)
         send_vec(COMP_W'(i * 7 - 3), COMP_W'(-i * 11), 24'sd5, COMP_W'(100 + i),
                  i == NVEC + 1);
      // all-zero pair
      send_vec('0, '0, '0, '0, 0);
      send_vec('0, '0, '0, '0, 1);
      run_random(100);

      set_config(24'd0, MODE_MASS);
      run_random(100);

      set_config(24'hFFFFFF, MODE_MASS);
      run_random(90);

      set_config(COMP_W'($urandom), MODE_PT);
      // equal pT everywhere: earlier vectors are kept
      for (int i = 0; i < 4; i++)
         send_vec(24'sd3000, -24'sd4000, COMP_W'(i * 100), 24'd9000, i == 3);
      // a full set with both highest pT at the tail
      for (int i = 0; i < NVEC; i++)
         send_vec(COMP_W'(i * 1000), COMP_W'(-i * 500), 24'sd7, 24'd20000, i == NVEC - 1);
      run_random(100);

      // Long receiver hold-off while requests keep coming.
      set_config(24'd91188, MODE_MASS);
      hold_request = 1;
      run_random(110);

      wait_idle();
      if (sb.pending.size() != 0) begin
         sb.errors++;
         $display("%0t: %0d responses missing", $time, sb.pending.size());
      end
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/pmr_pkg.sv
hw/rtl/pmr_ctrl.sv
hw/rtl/pmr_datapath.sv
hw/rtl/pair_mass_reconstruction_core.sv
hw/rtl/pmr_checker.sv
verif/tb_pair_mass_reconstruction_core.sv
